[sv/b64sc_pkg.sv]
// shared types, register indexes and alphabet functions for the base64 stream codec
`default_nettype none

package b64sc_pkg;

    localparam int unsigned RES_MAX = 4;
    localparam int unsigned CNT_W   = $clog2(RES_MAX + 1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // configuration register indexes
    localparam logic REG_DECODE_MODE      = 1'b0;
    localparam logic REG_ALPHABET_VARIANT = 1'b1;

    localparam logic [7:0] PAD_CHAR    = 8'h3D;
    localparam logic [7:0] STD_63_CHAR = 8'h2F;
    localparam logic [7:0] ALT_63_CHAR = 8'h25;

    typedef struct packed {
        logic [7:0] data;
        logic       dvalid;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [7:0] value;
        logic       vld;
        logic       last;
        logic       status;
    } t_result;

    typedef struct packed {
        logic [5:0] acc;
        logic [1:0] gp;
        logic [1:0] pads;
        logic       fail;
    } t_msg_state;

    function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic variant);
        logic [7:0] v8;
        v8 = {2'b00, v};
        if (v < 6'd26) begin
            return 8'h41 + v8;
        end else if (v < 6'd52) begin
            return 8'h61 + (v8 - 8'd26);
        end else if (v < 6'd62) begin
            return 8'h30 + (v8 - 8'd52);
        end else if (v == 6'd62) begin
            return 8'h2B;
        end else begin
            return variant ? ALT_63_CHAR : STD_63_CHAR;
        end
    endfunction

    // bit 6 set marks a character outside the alphabet
    function automatic logic [6:0] char_sextet(input logic [7:0] c, input logic variant);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
            return {1'b0, d[5:0]};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h61 + 8'd26;
            return {1'b0, d[5:0]};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30 + 8'd52;
            return {1'b0, d[5:0]};
        end else if (c == 8'h2B) begin
            return 7'd62;
        end else if (c == (variant ? ALT_63_CHAR : STD_63_CHAR)) begin
            return 7'd63;
        end else begin
            return 7'd64;
        end
    endfunction

    function automatic t_result make_res(input logic [7:0] value, input logic vld);
        t_result r;
        r.value  = value;
        r.vld    = vld;
        r.last   = 1'b0;
        r.status = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/b64sc_core.sv]
// per-item encode/decode logic: results and next message state from one item
`default_nettype none

module b64sc_core (
    input  wire                                           i_decode,
    input  wire                                           i_variant,
    input  var  b64sc_pkg::t_item                         i_item,
    input  var  b64sc_pkg::t_msg_state                    i_st,
    output b64sc_pkg::t_result [b64sc_pkg::RES_MAX-1:0]   o_res,
    output logic [b64sc_pkg::CNT_W-1:0]                   o_count,
    output b64sc_pkg::t_msg_state                         o_st
);

    logic [5:0] acc;
    logic [1:0] gp;
    logic [1:0] pads;
    logic       fail;
    logic [b64sc_pkg::CNT_W-1:0] n;
    logic [6:0] sx;
    logic [7:0] b;
    logic [1:0] last_idx;
    b64sc_pkg::t_result [b64sc_pkg::RES_MAX-1:0] res;

    always_comb begin
        acc      = i_st.acc;
        gp       = i_st.gp;
        pads     = i_st.pads;
        fail     = i_st.fail;
        n        = '0;
        res      = '0;
        b        = i_item.data;
        sx       = b64sc_pkg::char_sextet(b, i_variant);
        last_idx = 2'd0;

        if (!i_decode) begin
            if (i_item.dvalid) begin
                case (gp)
                    2'd0: begin
                        res[n[1:0]] = b64sc_pkg::make_res(
                            b64sc_pkg::sextet_char(b[7:2], i_variant), 1'b1);
                        n   = n + b64sc_pkg::CNT_ONE;
                        acc = {4'd0, b[1:0]};
                        gp  = 2'd1;
                    end
                    2'd1: begin
                        res[n[1:0]] = b64sc_pkg::make_res(
                            b64sc_pkg::sextet_char({acc[1:0], b[7:4]}, i_variant), 1'b1);
                        n   = n + b64sc_pkg::CNT_ONE;
                        acc = {2'd0, b[3:0]};
                        gp  = 2'd2;
                    end
                    default: begin
                        res[n[1:0]] = b64sc_pkg::make_res(
                            b64sc_pkg::sextet_char({acc[3:0], b[7:6]}, i_variant), 1'b1);
                        n   = n + b64sc_pkg::CNT_ONE;
                        res[n[1:0]] = b64sc_pkg::make_res(
                            b64sc_pkg::sextet_char(b[5:0], i_variant), 1'b1);
                        n   = n + b64sc_pkg::CNT_ONE;
                        acc = 6'd0;
                        gp  = 2'd0;
                    end
                endcase
            end
            if (i_item.last) begin
                // finish a short group and pad it out to four characters
                if (gp == 2'd1) begin
                    res[n[1:0]] = b64sc_pkg::make_res(
                        b64sc_pkg::sextet_char({acc[1:0], 4'd0}, i_variant), 1'b1);
                    n = n + b64sc_pkg::CNT_ONE;
                    res[n[1:0]] = b64sc_pkg::make_res(b64sc_pkg::PAD_CHAR, 1'b1);
                    n = n + b64sc_pkg::CNT_ONE;
                    res[n[1:0]] = b64sc_pkg::make_res(b64sc_pkg::PAD_CHAR, 1'b1);
                    n = n + b64sc_pkg::CNT_ONE;
                end else if (gp == 2'd2) begin
                    res[n[1:0]] = b64sc_pkg::make_res(
                        b64sc_pkg::sextet_char({acc[3:0], 2'd0}, i_variant), 1'b1);
                    n = n + b64sc_pkg::CNT_ONE;
                    res[n[1:0]] = b64sc_pkg::make_res(b64sc_pkg::PAD_CHAR, 1'b1);
                    n = n + b64sc_pkg::CNT_ONE;
                end
            end
        end else begin
            if (i_item.dvalid && !fail) begin
                if (b == b64sc_pkg::PAD_CHAR) begin
                    if (pads >= 2'd2) begin
                        fail = 1'b1;
                    end else begin
                        pads = pads + 2'd1;
                    end
                end else if (sx[6] || pads != 2'd0) begin
                    // bad character, or data after a pad
                    fail = 1'b1;
                end else begin
                    case (gp)
                        2'd0: begin
                            acc = sx[5:0];
                            gp  = 2'd1;
                        end
                        2'd1: begin
                            res[n[1:0]] = b64sc_pkg::make_res({acc, sx[5:4]}, 1'b1);
                            n   = n + b64sc_pkg::CNT_ONE;
                            acc = {2'd0, sx[3:0]};
                            gp  = 2'd2;
                        end
                        2'd2: begin
                            res[n[1:0]] = b64sc_pkg::make_res({acc[3:0], sx[5:2]}, 1'b1);
                            n   = n + b64sc_pkg::CNT_ONE;
                            acc = {4'd0, sx[1:0]};
                            gp  = 2'd3;
                        end
                        default: begin
                            res[n[1:0]] = b64sc_pkg::make_res({acc[1:0], sx[5:0]}, 1'b1);
                            n   = n + b64sc_pkg::CNT_ONE;
                            acc = 6'd0;
                            gp  = 2'd0;
                        end
                    endcase
                end
            end
            if (i_item.last) begin
                if (gp == 2'd1) begin
                    fail = 1'b1;
                end
                if (pads != 2'd0 && (gp + pads) != 2'd0) begin
                    fail = 1'b1;
                end
            end
        end

        if (i_item.last) begin
            if (n == '0) begin
                res[0] = b64sc_pkg::make_res(8'd0, 1'b0);
                n      = b64sc_pkg::CNT_ONE;
            end
            last_idx             = n[1:0] - 2'd1;
            res[last_idx].last   = 1'b1;
            res[last_idx].status = i_decode & fail;
            acc  = 6'd0;
            gp   = 2'd0;
            pads = 2'd0;
            fail = 1'b0;
        end

        o_res        = res;
        o_count      = n;
        o_st.acc     = acc;
        o_st.gp      = gp;
        o_st.pads    = pads;
        o_st.fail    = fail;
    end

endmodule

`default_nettype wire

[sv/base64_stream_codec_unit.sv]
// base64 stream codec top level: input register, codec logic, result bank
//
//  channel   | direction | tdata            | tuser (lsb first)          | tlast
//  s_axis    | in        | in_byte [7:0]    | byte_valid                 | message_end
//  m_axis    | out       | out_value [7:0]  | value_valid, status        | out_last
//  i_cfg_*   | in        | we, idx [0:0], data [0:0]; 0 decode_mode, 1 alphabet_variant
//
// an item is held in the input register, then its 0..4 results load the result
// bank together; the bank drains one result per cycle while m_axis is ready;
// an item gives up to 2 results when encoding, up to 4 when a message end closes
// a short group, and at most 1 when decoding
// a new item is taken while the last result of the previous one is delivered
// reset is synchronous and clears all control state; no clearing pass
// a stall on m_axis holds the bank, then the input register, then s_axis_tready
`default_nettype none

module base64_stream_codec_unit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,   // in_byte
    input  wire        s_axis_tuser,   // byte_valid
    input  wire        s_axis_tlast,
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_value
    output logic [1:0] m_axis_tuser,   // [0] value_valid, [1] status
    output logic       m_axis_tlast,
    input  wire        i_cfg_we,
    input  wire        i_cfg_idx,
    input  wire        i_cfg_data
);

    localparam int unsigned RES_MAX = b64sc_pkg::RES_MAX;
    localparam int unsigned CNT_W   = b64sc_pkg::CNT_W;

    logic                  r_decode_mode;
    logic                  r_variant;
    b64sc_pkg::t_msg_state r_st;
    b64sc_pkg::t_msg_state core_st;
    b64sc_pkg::t_item      r_in;
    logic                  r_in_vld;
    b64sc_pkg::t_result [RES_MAX-1:0] r_res;
    b64sc_pkg::t_result [RES_MAX-1:0] n_res;
    b64sc_pkg::t_result [RES_MAX-1:0] core_res;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic [CNT_W-1:0]      core_cnt;
    logic                  take;
    logic                  bank_free;
    logic                  process;
    logic                  in_acc;
    logic                  mode_wr;

    b64sc_core u_core (
        .i_decode  (r_decode_mode),
        .i_variant (r_variant),
        .i_item    (r_in),
        .i_st      (r_st),
        .o_res     (core_res),
        .o_count   (core_cnt),
        .o_st      (core_st)
    );

    assign take          = m_axis_tvalid && m_axis_tready;
    assign bank_free     = (r_cnt == '0) || (r_cnt == CNT_W'(1) && m_axis_tready);
    assign process       = r_in_vld && bank_free;
    assign s_axis_tready = !r_in_vld || bank_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign mode_wr       = i_cfg_we && (i_cfg_idx == b64sc_pkg::REG_DECODE_MODE);

    assign m_axis_tvalid   = (r_cnt != '0);
    assign m_axis_tdata    = r_res[0].value;
    assign m_axis_tuser[0] = r_res[0].vld;
    assign m_axis_tuser[1] = r_res[0].status;
    assign m_axis_tlast    = r_res[0].last;

    always_comb begin
        n_res = r_res;
        n_cnt = r_cnt;
        if (process) begin
            n_res = core_res;
            n_cnt = core_cnt;
        end else if (take) begin
            for (int i = 0; i < RES_MAX - 1; i++) begin
                n_res[i] = r_res[i+1];
            end
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode <= 1'b0;
            r_variant     <= 1'b0;
            r_st          <= '0;
            r_in_vld      <= 1'b0;
            r_cnt         <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (process) begin
                r_in_vld <= 1'b0;
            end
            // a mode write restarts the message and wins over item processing
            if (mode_wr) begin
                r_decode_mode <= i_cfg_data;
                r_st          <= '0;
            end else if (process) begin
                r_st <= core_st;
            end
            if (i_cfg_we && i_cfg_idx == b64sc_pkg::REG_ALPHABET_VARIANT) begin
                r_variant <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in.data   <= s_axis_tdata;
            r_in.dvalid <= s_axis_tuser;
            r_in.last   <= s_axis_tlast;
        end
        r_res <= n_res;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(RES_MAX))
        else $error("result count beyond bank depth");

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> r_cnt == CNT_W'(1))
        else $error("message end result is not the last one in the bank");

    a_enc_no_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_decode_mode |-> !r_st.fail)
        else $error("failure flag set while encoding");

    a_pad_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.pads != 2'd3)
        else $error("pad count beyond two");

endmodule

`default_nettype wire
